// ----- src/hsv2rgb_pkg.sv -----
// Package: word types and constants for the HSV to RGB converter.
package hsv2rgb_pkg;

	// Input word: hue as Q0.16 turn, saturation and brightness as 8-bit levels
	typedef struct packed {
		logic [15:0] hue;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
	} hsv_t;

	// Output word: PWM compare levels
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// Full scale of sat*x: 255 * 65536
	localparam logic [23:0] UNITY_Q16 = 24'd16711680;

	// Reciprocal of 255: floor(m / 255) = (m * 0x8081) >> 23 for any 16-bit m
	localparam logic [15:0] RECIP_255 = 16'h8081;
	localparam int unsigned RECIP_SHIFT = 23;

	// Hue sectors, named by the color span they cover
	localparam logic [2:0] SECT_RED_YELLOW    = 3'd0;
	localparam logic [2:0] SECT_YELLOW_GREEN  = 3'd1;
	localparam logic [2:0] SECT_GREEN_CYAN    = 3'd2;
	localparam logic [2:0] SECT_CYAN_BLUE     = 3'd3;
	localparam logic [2:0] SECT_BLUE_MAGENTA  = 3'd4;
	localparam logic [2:0] SECT_MAGENTA_RED   = 3'd5;

endpackage

// ----- src/hsv_to_rgb_converter.sv -----
// Top level: six-stage pipelined HSV to RGB converter with valid/ready channels.
// Pipeline depth: six register stages between the input handshake and the output.
// Throughput: one word per cycle while rgb_ready holds; each stage has its own valid bit and enable,
// so bubbles close up behind a stalled output and stalls lose nothing.
// Stages: sector split, sat*frac multiply, level terms, val multiply,
// divide by 255 via reciprocal multiply, channel select into output register.
// Reset clears all stage valid bits; payload registers are not reset.
module hsv_to_rgb_converter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               hsv_valid,
	output logic               hsv_ready,
	input  hsv2rgb_pkg::hsv_t  hsv,
	output logic               rgb_valid,
	input  logic               rgb_ready,
	output hsv2rgb_pkg::rgb_t  rgb
);
	import hsv2rgb_pkg::*;

	// Stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	// Stage enables
	logic en1, en2, en3, en4, en5, en6;

	// Stage 1 payload
	logic [2:0]  sector_s1;
	logic [15:0] frac_s1;
	logic [7:0]  sat_s1;
	logic [7:0]  val_s1;
	// Stage 2 payload
	logic [2:0]  sector_s2;
	logic [23:0] sf_s2;
	logic [7:0]  sat_s2;
	logic [7:0]  val_s2;
	// Stage 3 payload
	logic [2:0]  sector_s3;
	logic [23:0] ap_s3, aq_s3, at_s3;
	logic [7:0]  val_s3;
	// Stage 4 payload
	logic [2:0]  sector_s4;
	logic [15:0] mp_s4, mq_s4, mt_s4;
	logic [7:0]  val_s4;
	// Stage 5 payload
	logic [2:0]  sector_s5;
	logic [7:0]  lp_s5, lq_s5, lt_s5;
	logic [7:0]  val_s5;
	// Stage 6 payload
	rgb_t        rgb_s6;

	// Combinational terms
	logic [18:0] turn6;
	logic [31:0] np, nq, nt;
	logic [31:0] dp, dq, dt;
	rgb_t        rgb_sel;

	// Advance a stage when it is empty or the next stage advances
	assign en6 = !v_s6 || rgb_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign hsv_ready = en1;
	assign rgb_valid = v_s6;
	assign rgb       = rgb_s6;

	// Move valid bits along the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= hsv_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// Stage 1: split hue*6 into sector and fraction
	assign turn6 = {1'b0, hsv.hue, 2'b00} + {2'b00, hsv.hue, 1'b0};

	always_ff @(posedge clk) begin
		if (en1) begin
			sector_s1 <= turn6[18:16];
			frac_s1   <= turn6[15:0];
			sat_s1    <= hsv.saturation;
			val_s1    <= hsv.brightness;
		end
	end

	// Stage 2: saturation times fraction
	always_ff @(posedge clk) begin
		if (en2) begin
			sector_s2 <= sector_s1;
			sf_s2     <= 24'(sat_s1) * 24'(frac_s1);
			sat_s2    <= sat_s1;
			val_s2    <= val_s1;
		end
	end

	// Stage 3: form 255*65536 - sat*x for x = 1, frac, 1 - frac
	always_ff @(posedge clk) begin
		if (en3) begin
			sector_s3 <= sector_s2;
			ap_s3     <= UNITY_Q16 - {sat_s2, 16'h0000};
			aq_s3     <= UNITY_Q16 - sf_s2;
			at_s3     <= UNITY_Q16 - {sat_s2, 16'h0000} + sf_s2;
			val_s3    <= val_s2;
		end
	end

	// Stage 4: scale by value, keep the integer part over 65536
	assign np = 32'(val_s3) * 32'(ap_s3);
	assign nq = 32'(val_s3) * 32'(aq_s3);
	assign nt = 32'(val_s3) * 32'(at_s3);

	always_ff @(posedge clk) begin
		if (en4) begin
			sector_s4 <= sector_s3;
			mp_s4     <= np[31:16];
			mq_s4     <= nq[31:16];
			mt_s4     <= nt[31:16];
			val_s4    <= val_s3;
		end
	end

	// Stage 5: divide by 255 through the reciprocal
	assign dp = 32'(mp_s4) * 32'(RECIP_255);
	assign dq = 32'(mq_s4) * 32'(RECIP_255);
	assign dt = 32'(mt_s4) * 32'(RECIP_255);

	always_ff @(posedge clk) begin
		if (en5) begin
			sector_s5 <= sector_s4;
			lp_s5     <= dp[RECIP_SHIFT +: 8];
			lq_s5     <= dq[RECIP_SHIFT +: 8];
			lt_s5     <= dt[RECIP_SHIFT +: 8];
			val_s5    <= val_s4;
		end
	end

	// Stage 6: route levels to channels by sector
	always_comb begin
		rgb_sel.red   = val_s5;
		rgb_sel.green = val_s5;
		rgb_sel.blue  = val_s5;
		case (sector_s5)
			SECT_YELLOW_GREEN: begin
				rgb_sel.red  = lq_s5;
				rgb_sel.blue = lp_s5;
			end
			SECT_GREEN_CYAN: begin
				rgb_sel.red  = lp_s5;
				rgb_sel.blue = lt_s5;
			end
			SECT_CYAN_BLUE: begin
				rgb_sel.red   = lp_s5;
				rgb_sel.green = lq_s5;
			end
			SECT_BLUE_MAGENTA: begin
				rgb_sel.red   = lt_s5;
				rgb_sel.green = lp_s5;
			end
			SECT_MAGENTA_RED: begin
				rgb_sel.green = lp_s5;
				rgb_sel.blue  = lq_s5;
			end
			default: begin
				rgb_sel.green = lt_s5;
				rgb_sel.blue  = lp_s5;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			rgb_s6 <= rgb_sel;
		end
	end

endmodule
